>>> sv/cisc_pkg.sv
package cisc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int GUARD = 8;
  localparam int Z_FRAC = 13;
  localparam int TOL_FRAC = 16;

  localparam logic        RST_BINOMIAL = 1'b1;
  localparam logic [15:0] RST_TOLERANCE = 16'd3277;
  localparam logic [15:0] RST_BATCH = 16'd1;
  localparam logic [15:0] RST_Z = 16'd16056;

  typedef enum logic [1:0] {
    CFG_BINOMIAL = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_BATCH = 2'd2,
    CFG_Z = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_SCALE,
    OP_SCALED,
    OP_FIRST,
    OP_DIV_MEAN,
    OP_MEAN,
    OP_MUL_SQ,
    OP_MUL_SQN,
    OP_DIV_VAR,
    OP_VAR,
    OP_MUL_P,
    OP_MUL_NB,
    OP_DIV_P,
    OP_DIV_VN,
    OP_SQRT,
    OP_Z,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCALE,
    S_SCALE_W,
    S_SCALED,
    S_BRANCH,
    S_MEAN_W,
    S_MEAN,
    S_SQ,
    S_SQ_W,
    S_SQN,
    S_SQN_W,
    S_VDIV,
    S_VDIV_W,
    S_VUPD,
    S_HALF,
    S_P_W,
    S_NB,
    S_NB_W,
    S_PDIV,
    S_HDIV_W,
    S_SQRT,
    S_SQRT_W,
    S_Z,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic n_is_one;
    logic binomial;
    logic out_busy;
  } stat_t;

endpackage

>>> sv/confidence_interval_stop_check.sv
// Sequential confidence-interval stopping check.
// The input channel (in_valid, in_ready, in_sample_value) takes one batch sample per
// transaction. Each sample yields exactly one result transaction on the output channel
// (out_valid, out_ready and the five result fields): the sample count, the running
// mean, the sample variance, the confidence half-width and the stop flag.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user is bound to
// write it only while the block is idle, as the block does not enforce this. Index 0 selects
// binomial mode, 1 the tolerance, 2 the batch size, 3 the z value. The time from acceptance
// to result is set by the shared radix-2 divider, which works through up to four divisions,
// plus a square root and up to two multiplications. A later sample in normal mode takes the
// longest; a first sample in normal mode the shortest. One item is in work at a time, and
// the next sample is taken only after the result of the last one has been posted.
// Synchronous reset (rst_n low) restores the default registers, clears the count, the
// mean and the variance, and empties the output register.
// If the receiver stalls, the finished result waits in the output register; the block
// still accepts and works on the next sample, holding only its completed result until
// the earlier transaction has been taken.
module confidence_interval_stop_check #(
  parameter int FRACTION_BITS = cisc_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_stop_ready,
  output logic [31:0]        out_sample_total,
  output logic signed [31:0] out_running_mean,
  output logic [63:0]        out_running_variance,
  output logic [31:0]        out_half_width,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import cisc_pkg::*;

  // Commands flow from the sequencer to the datapath; unit completion and
  // mode flags flow back.
  cmd_t  cmd;
  stat_t stat;

  cisc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cisc_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_sample_value      (in_sample_value),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_stop_ready       (out_stop_ready),
    .out_sample_total     (out_sample_total),
    .out_running_mean     (out_running_mean),
    .out_running_variance (out_running_variance),
    .out_half_width       (out_half_width),
    .cmd                  (cmd),
    .stat                 (stat)
  );

endmodule

>>> sv/cisc_div.sv
module cisc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import cisc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] dsr_r;
  logic [63:0] rem_nxt;
  logic [63:0] quo_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_r, quo_r[63]};
    diff = shifted - {1'b0, dsr_r};
    ge = shifted >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[63:0] : shifted[63:0];
    quo_nxt = {quo_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'd0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/cisc_sqrt.sv
module cisc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import cisc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] src_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [33:0] rem_nxt;
  logic [31:0] root_nxt;
  logic [35:0] sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // Two radicand bits per cycle, one root bit out.
  always_comb begin
    sh = {rem_r, src_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    diff = sh - trial;
    ge = sh >= trial;
    rem_nxt = ge ? diff[33:0] : sh[33:0];
    root_nxt = {root_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r <= radicand;
      rem_r <= 34'd0;
      root_r <= 32'd0;
    end else if (busy_r) begin
      src_r <= {src_r[61:0], 2'b00};
      rem_r <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> sv/cisc_ctrl.sv
module cisc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cisc_pkg::stat_t stat,
  output cisc_pkg::cmd_t  cmd
);
  import cisc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op = OP_DIV_SCALE;
        state_nxt = S_SCALE_W;
      end
      S_SCALE_W: if (stat.div_done) state_nxt = S_SCALED;
      S_SCALED: begin
        cmd.op = OP_SCALED;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (stat.n_is_one) begin
          cmd.op = OP_FIRST;
          state_nxt = S_HALF;
        end else begin
          cmd.op = OP_DIV_MEAN;
          state_nxt = S_MEAN_W;
        end
      end
      S_MEAN_W: if (stat.div_done) state_nxt = S_MEAN;
      S_MEAN: begin
        cmd.op = OP_MEAN;
        state_nxt = stat.binomial ? S_HALF : S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_MUL_SQ;
        state_nxt = S_SQ_W;
      end
      S_SQ_W: if (stat.mul_done) state_nxt = S_SQN;
      S_SQN: begin
        cmd.op = OP_MUL_SQN;
        state_nxt = S_SQN_W;
      end
      S_SQN_W: if (stat.mul_done) state_nxt = S_VDIV;
      S_VDIV: begin
        cmd.op = OP_DIV_VAR;
        state_nxt = S_VDIV_W;
      end
      S_VDIV_W: if (stat.div_done) state_nxt = S_VUPD;
      S_VUPD: begin
        cmd.op = OP_VAR;
        state_nxt = S_HALF;
      end
      S_HALF: begin
        if (stat.binomial) begin
          cmd.op = OP_MUL_P;
          state_nxt = S_P_W;
        end else begin
          cmd.op = OP_DIV_VN;
          state_nxt = S_HDIV_W;
        end
      end
      S_P_W: if (stat.mul_done) state_nxt = S_NB;
      S_NB: begin
        cmd.op = OP_MUL_NB;
        state_nxt = S_NB_W;
      end
      S_NB_W: if (stat.mul_done) state_nxt = S_PDIV;
      S_PDIV: begin
        cmd.op = OP_DIV_P;
        state_nxt = S_HDIV_W;
      end
      S_HDIV_W: if (stat.div_done) state_nxt = S_SQRT;
      S_SQRT: begin
        cmd.op = OP_SQRT;
        state_nxt = S_SQRT_W;
      end
      S_SQRT_W: if (stat.sqrt_done) state_nxt = S_Z;
      S_Z: begin
        cmd.op = OP_Z;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/cisc_dp.sv
module cisc_dp #(
  parameter int FRACTION_BITS = cisc_pkg::FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic signed [31:0]      in_sample_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_stop_ready,
  output logic [31:0]             out_sample_total,
  output logic signed [31:0]      out_running_mean,
  output logic [63:0]             out_running_variance,
  output logic [31:0]             out_half_width,
  input  cisc_pkg::cmd_t          cmd,
  output cisc_pkg::stat_t         stat
);
  import cisc_pkg::*;

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRACTION_BITS;

  // Configuration registers.
  logic        binomial_r;
  logic [15:0] tol_r;
  logic [15:0] batch_r;
  logic [15:0] z_r;

  // Running state.
  logic [31:0]        n_r;
  logic signed [39:0] store_r;
  logic [63:0]        var_r;

  // Per-item working registers.
  logic signed [31:0] smp_r;
  logic signed [39:0] scaled_r;
  logic               dneg_r;
  logic [63:0]        dmag_r;
  logic [63:0]        sqn_r;
  logic [63:0]        pmag_r;
  logic               pneg_r;
  logic [31:0]        half_r;
  logic signed [49:0] bound_r;
  logic               out_valid_r;

  // Multi-cycle multiplier: four 32x32 partial products.
  logic [63:0]  mul_a_r;
  logic [63:0]  mul_b_r;
  logic [2:0]   mul_step_r;
  logic         mul_busy_r;
  logic         mul_done_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_k_r;
  logic [127:0] acc_r;
  logic [63:0]  mul_a_in;
  logic [63:0]  mul_b_in;
  logic         mul_start;
  logic [1:0]   mul_k;
  logic [31:0]  mul_pa;
  logic [31:0]  mul_pb;
  logic [127:0] pp_shifted;

  // Shared units.
  logic        div_start;
  logic [63:0] div_dividend;
  logic [63:0] div_divisor;
  logic        div_done;
  logic [63:0] div_q;
  logic        sqrt_start;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  // Derived values.
  logic [15:0]        batch_eff;
  logic [39:0]        smp_mag;
  logic signed [40:0] diff;
  logic [40:0]        diff_mag;
  logic signed [31:0] mean;
  logic [31:0]        mean_mag;
  logic signed [33:0] one_minus;
  logic [33:0]        om_mag;
  logic signed [40:0] mean_sum;
  logic [64:0]        var_sum;
  logic [63:0]        var_less;
  logic [63:0]        sq_sat;
  logic [63:0]        sqn_sat;
  logic [47:0]        z_prod;
  logic [34:0]        z_shift;
  logic [31:0]        half_nxt;
  logic signed [48:0] bound_prod;
  logic [49:0]        half_cmp;
  logic               stop_nxt;

  always_comb begin
    batch_eff = (batch_r == 16'd0) ? 16'd1 : batch_r;
    smp_mag = smp_r[31] ? 40'(-{{8{smp_r[31]}}, smp_r}) << GUARD
                        : 40'({8'd0, smp_r}) << GUARD;
    diff = {scaled_r[39], scaled_r} - {store_r[39], store_r};
    diff_mag = diff[40] ? 41'(-diff) : 41'(diff);
    mean = store_r[39:8];
    mean_mag = mean[31] ? 32'(-mean) : 32'(mean);
    one_minus = ONE - 34'(mean);
    om_mag = one_minus[33] ? 34'(-one_minus) : 34'(one_minus);
    mean_sum = {store_r[39], store_r}
             + (dneg_r ? -$signed({1'b0, div_q[39:0]}) : $signed({1'b0, div_q[39:0]}));
    sq_sat = (acc_r[127:80] != 48'd0) ? {64{1'b1}} : acc_r[79:16];
    sqn_sat = (acc_r[127:64] != 64'd0) ? {64{1'b1}} : acc_r[63:0];
    var_less = var_r - div_q;
    var_sum = {1'b0, var_less} + {1'b0, sqn_r};
    z_prod = 48'(z_r) * 48'(sqrt_root);
    z_shift = z_prod[47:Z_FRAC];
    half_nxt = (z_shift[34:32] != 3'd0) ? {32{1'b1}} : z_shift[31:0];
    if (binomial_r && pneg_r) half_nxt = {32{1'b1}};
    bound_prod = $signed({1'b0, tol_r}) * mean;
    half_cmp = {2'b00, half_r, 16'd0};
    stop_nxt = (n_r > 32'd1) && (mean != 32'sd0) && !bound_r[49]
               && (half_cmp <= bound_r);
  end

  // Operand selection for the shared units.
  always_comb begin
    div_start = 1'b0;
    div_dividend = var_r;
    div_divisor = 64'(n_r);
    mul_start = 1'b0;
    mul_a_in = dmag_r;
    mul_b_in = dmag_r;
    sqrt_start = 1'b0;
    unique case (cmd.op)
      OP_DIV_SCALE: begin
        div_start = 1'b1;
        div_dividend = 64'(smp_mag);
        div_divisor = 64'(batch_eff);
      end
      OP_DIV_MEAN: begin
        div_start = 1'b1;
        div_dividend = 64'(diff_mag);
      end
      OP_DIV_VAR: begin
        div_start = 1'b1;
        div_divisor = 64'(n_r - 32'd1);
      end
      OP_DIV_VN: div_start = 1'b1;
      OP_DIV_P: begin
        div_start = 1'b1;
        div_dividend = pmag_r;
        div_divisor = acc_r[63:0];
      end
      OP_MUL_SQ: mul_start = 1'b1;
      OP_MUL_SQN: begin
        mul_start = 1'b1;
        mul_a_in = sq_sat;
        mul_b_in = 64'(n_r);
      end
      OP_MUL_P: begin
        mul_start = 1'b1;
        mul_a_in = 64'(mean_mag);
        mul_b_in = 64'(om_mag);
      end
      OP_MUL_NB: begin
        mul_start = 1'b1;
        mul_a_in = 64'(n_r);
        mul_b_in = 64'(batch_eff);
      end
      OP_SQRT: sqrt_start = 1'b1;
      default: ;
    endcase
  end

  cisc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  cisc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_q),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Multiplier sequencing.
  always_comb begin
    mul_k = mul_step_r[1:0];
    mul_pa = mul_k[1] ? mul_a_r[63:32] : mul_a_r[31:0];
    mul_pb = mul_k[0] ? mul_b_r[63:32] : mul_b_r[31:0];
    unique case (pp_k_r)
      2'd0: pp_shifted = 128'(pp_r);
      2'd3: pp_shifted = 128'(pp_r) << 64;
      default: pp_shifted = 128'(pp_r) << 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_step_r <= 3'd0;
    end else begin
      mul_done_r <= 1'b0;
      if (mul_start) begin
        mul_busy_r <= 1'b1;
        mul_step_r <= 3'd0;
      end else if (mul_busy_r) begin
        mul_step_r <= mul_step_r + 3'd1;
        if (mul_step_r == 3'd4) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a_r <= mul_a_in;
      mul_b_r <= mul_b_in;
      acc_r <= 128'd0;
    end else if (mul_busy_r) begin
      if (mul_step_r != 3'd4) begin
        pp_r <= 64'(mul_pa) * 64'(mul_pb);
        pp_k_r <= mul_k;
      end
      if (mul_step_r != 3'd0) acc_r <= acc_r + pp_shifted;
    end
  end

  // Configuration, count, mean, variance and output flag: control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binomial_r <= RST_BINOMIAL;
      tol_r <= RST_TOLERANCE;
      batch_r <= RST_BATCH;
      z_r <= RST_Z;
      n_r <= 32'd0;
      store_r <= 40'sd0;
      var_r <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BINOMIAL: binomial_r <= cfg_wdata[0];
          CFG_TOLERANCE: tol_r <= cfg_wdata;
          CFG_BATCH: batch_r <= cfg_wdata;
          CFG_Z: z_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: if (n_r != {32{1'b1}}) n_r <= n_r + 32'd1;
        OP_FIRST: begin
          store_r <= scaled_r;
          if (!binomial_r) var_r <= 64'd0;
        end
        OP_MEAN: store_r <= mean_sum[39:0];
        OP_VAR: var_r <= var_sum[64] ? {64{1'b1}} : var_sum[63:0];
        OP_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Working and output payload.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: smp_r <= in_sample_value;
      OP_SCALED: scaled_r <= smp_r[31] ? -$signed(div_q[39:0]) : $signed(div_q[39:0]);
      OP_DIV_MEAN: dneg_r <= diff[40];
      OP_MEAN: dmag_r <= div_q;
      OP_DIV_VAR: sqn_r <= sqn_sat;
      OP_MUL_P: pneg_r <= (mean != 32'sd0) && (one_minus != 34'sd0)
                          && (mean[31] ^ one_minus[33]);
      OP_MUL_NB: pmag_r <= acc_r[63:0];
      OP_Z: begin
        half_r <= half_nxt;
        bound_r <= 50'(bound_prod);
      end
      OP_OUT: begin
        out_stop_ready <= stop_nxt;
        out_sample_total <= n_r;
        out_running_mean <= mean;
        out_running_variance <= binomial_r ? 64'd0 : var_r;
        out_half_width <= half_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.div_done = div_done;
    stat.sqrt_done = sqrt_done;
    stat.mul_done = mul_done_r;
    stat.n_is_one = (n_r == 32'd1);
    stat.binomial = binomial_r;
    stat.out_busy = out_valid_r && !out_ready;
  end

endmodule
